@@ sv/pbar_pkg.sv @@
`timescale 1ns / 1ps
package pbar_pkg;

   localparam int TimeW      = 18;
   localparam int DateW      = 27;
   localparam int PriceW     = 32;
   localparam int HmW        = 12;
   localparam int HourW      = 5;
   localparam int CycW       = 6;
   localparam int ModeW      = 2;
   localparam int ActW       = 2;
   localparam int CsrIdxW    = 2;
   localparam int CsrDataW   = 18;
   localparam int CntW       = 4;
   localparam int Lanes      = 4;
   localparam int RecipW     = 19;
   localparam int RecipShift = 25;
   localparam int PrepLast   = 4;

   localparam logic [RecipW-1:0] Recip100 = 19'd335545;

   localparam logic [CycW-1:0]  CycleReset        = 6'd1;
   localparam logic [ModeW-1:0] ModeReset         = 2'd0;
   localparam logic [TimeW-1:0] SessionOpenReset  = 18'd0;
   localparam logic [TimeW-1:0] SessionCloseReset = 18'd235959;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_BAR_CYCLE     = 2'd0,
      CSR_CHART_MODE    = 2'd1,
      CSR_SESSION_OPEN  = 2'd2,
      CSR_SESSION_CLOSE = 2'd3
   } csr_index_type;

   typedef enum logic [ModeW-1:0] {
      MODE_MINUTE = 2'd0,
      MODE_UPDATE = 2'd1,
      MODE_TICK   = 2'd2
   } chart_mode_type;

   typedef enum logic [ActW-1:0] {
      ACT_IGNORED   = 2'd0,
      ACT_UPDATED   = 2'd1,
      ACT_NEW_TICK  = 2'd2,
      ACT_NEW_TIMER = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      PRE_EVENT      = 3'd0,
      PRE_OPEN       = 3'd1,
      PRE_CLOSE      = 3'd2,
      PRE_OPEN_HOUR  = 3'd3,
      PRE_CLOSE_HOUR = 3'd4
   } pre_sel_type;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_PREP   = 6'b000010,
      S_INIT   = 6'b000100,
      S_STEP   = 6'b001000,
      S_BOUND  = 6'b010000,
      S_COMMIT = 6'b100000
   } state_type;

   typedef struct packed {
      logic        capture;
      logic        pre_en;
      pre_sel_type pre_sel;
      logic        rem_init;
      logic        rem_step;
      logic        bound_en;
      logic        commit;
   } cmd_type;

   // Exact for every 18-bit value: reciprocal of 100 scaled by 2^25.
   function automatic logic [HmW-1:0] div100(input logic [TimeW-1:0] x);
      logic [TimeW+RecipW-1:0] prod;
      prod = (TimeW+RecipW)'(x) * (TimeW+RecipW)'(Recip100);
      return prod[RecipShift +: HmW];
   endfunction

   function automatic logic [TimeW-1:0] times100(input logic [HmW-1:0] x);
      logic [TimeW-1:0] w;
      w = TimeW'(x);
      return (w << 6) + (w << 5) + (w << 2);
   endfunction

endpackage

@@ sv/pbar_ctrl.sv @@
`timescale 1ns / 1ps
module pbar_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pbar_pkg::cmd_type cmd
);

   pbar_pkg::state_type state_ff, state_in;
   logic [pbar_pkg::CntW-1:0] cnt_ff, cnt_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == pbar_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.pre_sel  = pbar_pkg::PRE_EVENT;
      case (state_ff)
         pbar_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               cnt_in      = '0;
               state_in    = pbar_pkg::S_PREP;
            end
         end
         pbar_pkg::S_PREP: begin
            cmd.pre_en = 1'b1;
            case (cnt_ff)
               4'd0:    cmd.pre_sel = pbar_pkg::PRE_EVENT;
               4'd1:    cmd.pre_sel = pbar_pkg::PRE_OPEN;
               4'd2:    cmd.pre_sel = pbar_pkg::PRE_CLOSE;
               4'd3:    cmd.pre_sel = pbar_pkg::PRE_OPEN_HOUR;
               default: cmd.pre_sel = pbar_pkg::PRE_CLOSE_HOUR;
            endcase
            if (cnt_ff == pbar_pkg::CntW'(pbar_pkg::PrepLast)) begin
               state_in = pbar_pkg::S_INIT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         pbar_pkg::S_INIT: begin
            cmd.rem_init = 1'b1;
            cnt_in       = '0;
            state_in     = pbar_pkg::S_STEP;
         end
         pbar_pkg::S_STEP: begin
            cmd.rem_step = 1'b1;
            if (cnt_ff == pbar_pkg::CntW'(pbar_pkg::HmW - 1)) begin
               state_in = pbar_pkg::S_BOUND;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         pbar_pkg::S_BOUND: begin
            cmd.bound_en = 1'b1;
            state_in     = pbar_pkg::S_COMMIT;
         end
         pbar_pkg::S_COMMIT: begin
            if (out_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = pbar_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = pbar_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pbar_pkg::S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ sv/pbar_dp.sv @@
`timescale 1ns / 1ps
module pbar_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  pbar_pkg::cmd_type                   cmd,
   input  logic                                req_type,
   input  logic        [pbar_pkg::TimeW-1:0]   req_event_time,
   input  logic        [pbar_pkg::DateW-1:0]   req_event_date,
   input  logic signed [pbar_pkg::PriceW-1:0]  req_price,
   input  logic                                csr_write,
   input  logic        [pbar_pkg::CsrIdxW-1:0] csr_index,
   input  logic        [pbar_pkg::CsrDataW-1:0] csr_data,
   output logic        [pbar_pkg::ActW-1:0]    rsp_action,
   output logic        [pbar_pkg::DateW-1:0]   rsp_bar_date,
   output logic        [pbar_pkg::TimeW-1:0]   rsp_bar_time,
   output logic signed [pbar_pkg::PriceW-1:0]  rsp_bar_open,
   output logic signed [pbar_pkg::PriceW-1:0]  rsp_bar_high,
   output logic signed [pbar_pkg::PriceW-1:0]  rsp_bar_low,
   output logic signed [pbar_pkg::PriceW-1:0]  rsp_bar_close
);

   localparam int LaneEvent = 0;
   localparam int LaneBar   = 1;
   localparam int LaneOpen  = 2;
   localparam int LaneClose = 3;

   logic [pbar_pkg::CycW-1:0]  bar_cycle_ff;
   logic [pbar_pkg::ModeW-1:0] chart_mode_ff;
   logic [pbar_pkg::TimeW-1:0] session_open_ff, session_close_ff;

   logic                               type_ff;
   logic        [pbar_pkg::TimeW-1:0]  time_ff;
   logic        [pbar_pkg::DateW-1:0]  date_ff;
   logic signed [pbar_pkg::PriceW-1:0] price_ff;

   logic [pbar_pkg::HmW-1:0]   hm_t_ff, hm_o_ff, hm_c_ff;
   logic [pbar_pkg::HourW-1:0] hour_o_ff, hour_c_ff;
   logic [pbar_pkg::TimeW-1:0] pre_x;
   logic [pbar_pkg::HmW-1:0]   pre_q;

   logic [pbar_pkg::HmW-1:0]  dvd_ff [pbar_pkg::Lanes];
   logic [pbar_pkg::HmW-1:0]  dvd_in [pbar_pkg::Lanes];
   logic [pbar_pkg::CycW-1:0] rem_ff [pbar_pkg::Lanes];
   logic [pbar_pkg::CycW-1:0] rem_in [pbar_pkg::Lanes];
   logic [pbar_pkg::CycW-1:0] cyc;
   logic [pbar_pkg::HmW-1:0]  min_o, min_c;

   logic [pbar_pkg::TimeW-1:0] bound_o_ff, bound_c_ff;

   logic        [pbar_pkg::DateW-1:0]  cur_date_ff, cur_date_in;
   logic        [pbar_pkg::HmW-1:0]    cur_hm_ff, cur_hm_in;
   logic signed [pbar_pkg::PriceW-1:0] cur_open_ff, cur_open_in;
   logic signed [pbar_pkg::PriceW-1:0] cur_high_ff, cur_high_in;
   logic signed [pbar_pkg::PriceW-1:0] cur_low_ff, cur_low_in;
   logic signed [pbar_pkg::PriceW-1:0] cur_close_ff, cur_close_in;
   pbar_pkg::action_type act_in;
   logic [pbar_pkg::HmW-1:0] cur_b, old_b;
   logic in_window, advanced;

   logic        [pbar_pkg::ActW-1:0]   rsp_action_ff;
   logic        [pbar_pkg::DateW-1:0]  rsp_date_ff;
   logic        [pbar_pkg::TimeW-1:0]  rsp_time_ff;
   logic signed [pbar_pkg::PriceW-1:0] rsp_open_ff, rsp_high_ff, rsp_low_ff, rsp_close_ff;

   assign cyc = (bar_cycle_ff == '0) ? pbar_pkg::CycW'(1) : bar_cycle_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bar_cycle_ff     <= pbar_pkg::CycleReset;
         chart_mode_ff    <= pbar_pkg::ModeReset;
         session_open_ff  <= pbar_pkg::SessionOpenReset;
         session_close_ff <= pbar_pkg::SessionCloseReset;
      end else if (csr_write) begin
         case (pbar_pkg::csr_index_type'(csr_index))
            pbar_pkg::CSR_BAR_CYCLE:     bar_cycle_ff     <= csr_data[pbar_pkg::CycW-1:0];
            pbar_pkg::CSR_CHART_MODE:    chart_mode_ff    <= csr_data[pbar_pkg::ModeW-1:0];
            pbar_pkg::CSR_SESSION_OPEN:  session_open_ff  <= csr_data[pbar_pkg::TimeW-1:0];
            pbar_pkg::CSR_SESSION_CLOSE: session_close_ff <= csr_data[pbar_pkg::TimeW-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         type_ff  <= req_type;
         time_ff  <= req_event_time;
         date_ff  <= req_event_date;
         price_ff <= req_price;
      end
   end

   always_comb begin
      case (cmd.pre_sel)
         pbar_pkg::PRE_EVENT:      pre_x = time_ff;
         pbar_pkg::PRE_OPEN:       pre_x = session_open_ff;
         pbar_pkg::PRE_CLOSE:      pre_x = session_close_ff;
         pbar_pkg::PRE_OPEN_HOUR:  pre_x = pbar_pkg::TimeW'(hm_o_ff);
         pbar_pkg::PRE_CLOSE_HOUR: pre_x = pbar_pkg::TimeW'(hm_c_ff);
         default:                  pre_x = time_ff;
      endcase
   end

   assign pre_q = pbar_pkg::div100(pre_x);

   always_ff @(posedge clock) begin
      if (cmd.pre_en) begin
         case (cmd.pre_sel)
            pbar_pkg::PRE_EVENT:      hm_t_ff   <= pre_q;
            pbar_pkg::PRE_OPEN:       hm_o_ff   <= pre_q;
            pbar_pkg::PRE_CLOSE:      hm_c_ff   <= pre_q;
            pbar_pkg::PRE_OPEN_HOUR:  hour_o_ff <= pre_q[pbar_pkg::HourW-1:0];
            pbar_pkg::PRE_CLOSE_HOUR: hour_c_ff <= pre_q[pbar_pkg::HourW-1:0];
            default: begin
            end
         endcase
      end
   end

   assign min_o = hm_o_ff -
      pbar_pkg::HmW'(pbar_pkg::times100(pbar_pkg::HmW'(hour_o_ff)));
   assign min_c = hm_c_ff -
      pbar_pkg::HmW'(pbar_pkg::times100(pbar_pkg::HmW'(hour_c_ff)));

   always_comb begin
      logic [pbar_pkg::CycW:0] shifted;
      shifted = '0;
      for (int i = 0; i < pbar_pkg::Lanes; i++) begin
         dvd_in[i] = dvd_ff[i];
         rem_in[i] = rem_ff[i];
      end
      if (cmd.rem_init) begin
         dvd_in[LaneEvent] = hm_t_ff;
         dvd_in[LaneBar]   = cur_hm_ff;
         dvd_in[LaneOpen]  = min_o;
         dvd_in[LaneClose] = min_c;
         for (int i = 0; i < pbar_pkg::Lanes; i++) begin
            rem_in[i] = '0;
         end
      end else if (cmd.rem_step) begin
         for (int i = 0; i < pbar_pkg::Lanes; i++) begin
            shifted = {rem_ff[i], dvd_ff[i][pbar_pkg::HmW-1]};
            if (shifted >= {1'b0, cyc}) begin
               shifted = shifted - {1'b0, cyc};
            end
            rem_in[i] = shifted[pbar_pkg::CycW-1:0];
            dvd_in[i] = dvd_ff[i] << 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < pbar_pkg::Lanes; i++) begin
         dvd_ff[i] <= dvd_in[i];
         rem_ff[i] <= rem_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.bound_en) begin
         bound_o_ff <= session_open_ff -
            pbar_pkg::times100(pbar_pkg::HmW'(rem_ff[LaneOpen]));
         bound_c_ff <= session_close_ff -
            pbar_pkg::times100(pbar_pkg::HmW'(rem_ff[LaneClose]));
      end
   end

   assign cur_b     = hm_t_ff - pbar_pkg::HmW'(rem_ff[LaneEvent]);
   assign old_b     = cur_hm_ff - pbar_pkg::HmW'(rem_ff[LaneBar]);
   assign advanced  = cur_b > old_b;
   assign in_window = !(time_ff < bound_o_ff || time_ff > bound_c_ff);

   always_comb begin
      cur_date_in  = cur_date_ff;
      cur_hm_in    = cur_hm_ff;
      cur_open_in  = cur_open_ff;
      cur_high_in  = cur_high_ff;
      cur_low_in   = cur_low_ff;
      cur_close_in = cur_close_ff;
      act_in       = pbar_pkg::ACT_IGNORED;
      if (type_ff) begin
         if (in_window && cur_hm_ff != '0 && advanced) begin
            cur_date_in = date_ff;
            cur_hm_in   = cur_b;
            cur_open_in = cur_close_ff;
            cur_high_in = cur_close_ff;
            cur_low_in  = cur_close_ff;
            act_in      = pbar_pkg::ACT_NEW_TIMER;
         end
      end else begin
         case (pbar_pkg::chart_mode_type'(chart_mode_ff))
            pbar_pkg::MODE_MINUTE: begin
               if (cur_hm_ff == '0 || cur_date_ff != date_ff || advanced) begin
                  cur_date_in  = date_ff;
                  cur_hm_in    = cur_b;
                  cur_open_in  = price_ff;
                  cur_high_in  = price_ff;
                  cur_low_in   = price_ff;
                  cur_close_in = price_ff;
                  act_in       = pbar_pkg::ACT_NEW_TICK;
               end else begin
                  if (price_ff > cur_high_ff) cur_high_in = price_ff;
                  if (price_ff < cur_low_ff) cur_low_in = price_ff;
                  cur_close_in = price_ff;
                  act_in       = pbar_pkg::ACT_UPDATED;
               end
            end
            pbar_pkg::MODE_TICK: begin
               act_in = pbar_pkg::ACT_IGNORED;
            end
            default: begin
               if (price_ff > cur_high_ff) cur_high_in = price_ff;
               if (price_ff < cur_low_ff) cur_low_in = price_ff;
               cur_close_in = price_ff;
               act_in       = pbar_pkg::ACT_UPDATED;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_date_ff  <= '0;
         cur_hm_ff    <= '0;
         cur_open_ff  <= '0;
         cur_high_ff  <= '0;
         cur_low_ff   <= '0;
         cur_close_ff <= '0;
      end else if (cmd.commit) begin
         cur_date_ff  <= cur_date_in;
         cur_hm_ff    <= cur_hm_in;
         cur_open_ff  <= cur_open_in;
         cur_high_ff  <= cur_high_in;
         cur_low_ff   <= cur_low_in;
         cur_close_ff <= cur_close_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_action_ff <= act_in;
         rsp_date_ff   <= cur_date_in;
         rsp_time_ff   <= pbar_pkg::times100(cur_hm_in);
         rsp_open_ff   <= cur_open_in;
         rsp_high_ff   <= cur_high_in;
         rsp_low_ff    <= cur_low_in;
         rsp_close_ff  <= cur_close_in;
      end
   end

   assign rsp_action    = rsp_action_ff;
   assign rsp_bar_date  = rsp_date_ff;
   assign rsp_bar_time  = rsp_time_ff;
   assign rsp_bar_open  = rsp_open_ff;
   assign rsp_bar_high  = rsp_high_ff;
   assign rsp_bar_low   = rsp_low_ff;
   assign rsp_bar_close = rsp_close_ff;

endmodule

@@ sv/price_bar_aggregator.sv @@
`timescale 1ns / 1ps
// An accepted request beat runs the 5-step reciprocal prescale, then the 12-step shared
// remainder unit (four lanes, one bit per cycle), a bound step and a commit that waits
// for a free output; the next request beat is taken only after that commit.
// A waiting result does not block the next request beat.
// Synchronous active-high reset clears the bar state and restores the registers.
module price_bar_aggregator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_type,
   input  logic        [pbar_pkg::TimeW-1:0]   req_event_time,
   input  logic        [pbar_pkg::DateW-1:0]   req_event_date,
   input  logic signed [pbar_pkg::PriceW-1:0]  req_price,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic        [pbar_pkg::ActW-1:0]    rsp_action,
   output logic        [pbar_pkg::DateW-1:0]   rsp_bar_date,
   output logic        [pbar_pkg::TimeW-1:0]   rsp_bar_time,
   output logic signed [pbar_pkg::PriceW-1:0]  rsp_bar_open,
   output logic signed [pbar_pkg::PriceW-1:0]  rsp_bar_high,
   output logic signed [pbar_pkg::PriceW-1:0]  rsp_bar_low,
   output logic signed [pbar_pkg::PriceW-1:0]  rsp_bar_close,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic        [pbar_pkg::CsrIdxW-1:0] csr_index,
   input  logic        [pbar_pkg::CsrDataW-1:0] csr_data
);

   pbar_pkg::cmd_type cmd;

   assign csr_ready = 1'b1;

   pbar_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   pbar_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_type       (req_type),
      .req_event_time (req_event_time),
      .req_event_date (req_event_date),
      .req_price      (req_price),
      .csr_write      (csr_valid && csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .rsp_action     (rsp_action),
      .rsp_bar_date   (rsp_bar_date),
      .rsp_bar_time   (rsp_bar_time),
      .rsp_bar_open   (rsp_bar_open),
      .rsp_bar_high   (rsp_bar_high),
      .rsp_bar_low    (rsp_bar_low),
      .rsp_bar_close  (rsp_bar_close)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while an item is in flight");

   a_no_early_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !$rose(rsp_valid))
      else $error("result beat raised right after a request beat");

   a_new_bar_flat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_action == pbar_pkg::ACT_NEW_TICK ||
                     rsp_action == pbar_pkg::ACT_NEW_TIMER)) |->
      (rsp_bar_high == rsp_bar_open && rsp_bar_low == rsp_bar_open &&
       rsp_bar_close == rsp_bar_open))
      else $error("a new bar does not start flat");

   a_high_above_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_bar_high >= rsp_bar_low))
      else $error("bar high below bar low");

endmodule

@@ bench/tb_price_bar_aggregator.sv @@
`timescale 1ns / 1ps
module tb_price_bar_aggregator;
   import pbar_pkg::*;

   localparam logic REQ_TRADE = 1'b0;
   localparam logic REQ_TIMER = 1'b1;
   localparam logic [ModeW-1:0] MODE_SPARE = 2'd3;
   localparam int unsigned IdleLimit = 4000;
   localparam int unsigned HoldCycles = 400;
   localparam int unsigned DrainCycles = 30;

   typedef struct packed {
      action_type               act;
      logic [DateW-1:0]         date;
      logic [TimeW-1:0]         tm;
      logic signed [PriceW-1:0] open;
      logic signed [PriceW-1:0] high;
      logic signed [PriceW-1:0] low;
      logic signed [PriceW-1:0] close;
   } bar_rec_type;

   typedef struct {
      bit                       is_cfg;
      logic [CycW-1:0]          cyc;
      logic [ModeW-1:0]         mode;
      logic [TimeW-1:0]         sess_open;
      logic [TimeW-1:0]         sess_close;
      logic                     kind;
      logic [TimeW-1:0]         tm;
      logic [DateW-1:0]         dt;
      logic signed [PriceW-1:0] px;
      bit                       typed;
      bar_rec_type              want;
   } script_row_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic                       req_type = 1'b0;
   logic [TimeW-1:0]           req_event_time = '0;
   logic [DateW-1:0]           req_event_date = '0;
   logic signed [PriceW-1:0]   req_price = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [ActW-1:0]            rsp_action;
   logic [DateW-1:0]           rsp_bar_date;
   logic [TimeW-1:0]           rsp_bar_time;
   logic signed [PriceW-1:0]   rsp_bar_open;
   logic signed [PriceW-1:0]   rsp_bar_high;
   logic signed [PriceW-1:0]   rsp_bar_low;
   logic signed [PriceW-1:0]   rsp_bar_close;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CsrIdxW-1:0]         csr_index = '0;
   logic [CsrDataW-1:0]        csr_data = '0;

   logic [CycW-1:0]            cfg_cycle = CycleReset;
   logic [ModeW-1:0]           cfg_mode = ModeReset;
   logic [TimeW-1:0]           cfg_open = SessionOpenReset;
   logic [TimeW-1:0]           cfg_close = SessionCloseReset;
   logic [DateW-1:0]           hold_date = '0;
   logic [TimeW-1:0]           hold_time = '0;
   logic signed [PriceW-1:0]   hold_open = '0;
   logic signed [PriceW-1:0]   hold_high = '0;
   logic signed [PriceW-1:0]   hold_low = '0;
   logic signed [PriceW-1:0]   hold_close = '0;

   bar_rec_type                pending_bars[$];
   script_row_type             script[$];
   int unsigned                errors = 0;
   int unsigned                items_sent = 0;
   int unsigned                bars_seen = 0;
   int unsigned                phases = 0;
   int unsigned                act_count[4];
   int unsigned                rsp_wait = 0;
   int unsigned                rsp_next;
   int unsigned                idle_run = 0;
   bit                         quiet_req = 1'b0;
   logic                       quiet_rsp = 1'b0;
   logic                       rsp_hold = 1'b0;

   price_bar_aggregator u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_event_time (req_event_time),
      .req_event_date (req_event_date),
      .req_price      (req_price),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_action     (rsp_action),
      .rsp_bar_date   (rsp_bar_date),
      .rsp_bar_time   (rsp_bar_time),
      .rsp_bar_open   (rsp_bar_open),
      .rsp_bar_high   (rsp_bar_high),
      .rsp_bar_low    (rsp_bar_low),
      .rsp_bar_close  (rsp_bar_close),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always #1 clock = ~clock;

   function automatic int unsigned span_minutes();
      return (cfg_cycle == '0) ? 32'd1 : 32'(cfg_cycle);
   endfunction

   // The floor applies to the whole HHMM number, not to the minutes alone.
   function automatic int unsigned minute_bucket(input int unsigned hhmmss);
      int unsigned hm;
      hm = hhmmss / 100;
      return hm - hm % span_minutes();
   endfunction

   function automatic int unsigned window_edge(input int unsigned v);
      int unsigned mins;
      mins = (v / 100) % 100;
      return (v / 10000) * 10000 + (mins - mins % span_minutes()) * 100 + v % 100;
   endfunction

   function automatic void start_bar(input logic [DateW-1:0] dt, input int unsigned bucket,
                                     input logic signed [PriceW-1:0] px);
      hold_date = dt;
      hold_time = TimeW'(bucket * 100);
      hold_open = px;
      hold_high = px;
      hold_low = px;
      hold_close = px;
   endfunction

   function automatic void extend_bar(input logic signed [PriceW-1:0] px);
      if (px > hold_high) begin
         hold_high = px;
      end
      if (px < hold_low) begin
         hold_low = px;
      end
      hold_close = px;
   endfunction

   function automatic bar_rec_type next_bar(input logic kind, input logic [TimeW-1:0] tm,
                                            input logic [DateW-1:0] dt,
                                            input logic signed [PriceW-1:0] px);
      bar_rec_type r;
      int unsigned now_b;
      int unsigned held_b;
      bit          in_window;
      now_b = minute_bucket(32'(tm));
      held_b = minute_bucket(32'(hold_time));
      r.act = ACT_IGNORED;
      if (kind == REQ_TIMER) begin
         in_window = !(32'(tm) < window_edge(32'(cfg_open)) ||
                       32'(tm) > window_edge(32'(cfg_close)));
         if (in_window && hold_time != '0 && now_b > held_b) begin
            start_bar(dt, now_b, hold_close);
            r.act = ACT_NEW_TIMER;
         end
      end else if (cfg_mode == MODE_MINUTE) begin
         if (hold_time == '0 || hold_date != dt || now_b > held_b) begin
            start_bar(dt, now_b, px);
            r.act = ACT_NEW_TICK;
         end else begin
            extend_bar(px);
            r.act = ACT_UPDATED;
         end
      end else if (cfg_mode != MODE_TICK) begin
         extend_bar(px);
         r.act = ACT_UPDATED;
      end
      r.date = hold_date;
      r.tm = hold_time;
      r.open = hold_open;
      r.high = hold_high;
      r.low = hold_low;
      r.close = hold_close;
      return r;
   endfunction

   function automatic void compare_bar();
      bar_rec_type want;
      if (pending_bars.size() == 0) begin
         if (errors < 10) begin
            $display("%0t: result beat arrived with no bar pending", $time);
         end
         errors++;
         return;
      end
      want = pending_bars.pop_front();
      bars_seen++;
      act_count[int'(want.act)]++;
      if (rsp_action !== want.act || rsp_bar_date !== want.date || rsp_bar_time !== want.tm ||
          rsp_bar_open !== want.open || rsp_bar_high !== want.high ||
          rsp_bar_low !== want.low || rsp_bar_close !== want.close) begin
         if (errors < 10) begin
            $display("%0t: bar mismatch, expected act %0d date %0d time %0d o/h/l/c %0d %0d %0d %0d",
                     $time, want.act, want.date, want.tm, want.open, want.high, want.low,
                     want.close);
            $display("%0t:                   got act %0d date %0d time %0d o/h/l/c %0d %0d %0d %0d",
                     $time, rsp_action, rsp_bar_date, rsp_bar_time, rsp_bar_open,
                     rsp_bar_high, rsp_bar_low, rsp_bar_close);
         end
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait <= 0;
      end else begin
         rsp_next = rsp_wait;
         if (rsp_valid && rsp_ready) begin
            compare_bar();
            rsp_next = quiet_rsp ? 0 : $urandom_range(0, 9);
         end else if (rsp_next > 0) begin
            rsp_next = rsp_next - 1;
         end
         rsp_wait <= rsp_next;
         rsp_ready <= (rsp_next == 0) && !rsp_hold;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_run <= 0;
      end else begin
         idle_run <= idle_run + 1;
         if (idle_run == IdleLimit) begin
            $display("watchdog: no beat accepted for %0d cycles", IdleLimit);
            $display("tb_price_bar_aggregator: errors");
            $finish;
         end
      end
   end

   task automatic hold_results(input int unsigned n);
      rsp_hold <= 1'b1;
      repeat (n) @(posedge clock);
      rsp_hold <= 1'b0;
   endtask

   task automatic offer_tick(input logic kind, input logic [TimeW-1:0] tm,
                             input logic [DateW-1:0] dt, input logic signed [PriceW-1:0] px,
                             input bit typed, input bar_rec_type typed_bar);
      int unsigned gap;
      bar_rec_type want;
      gap = quiet_req ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_event_time <= tm;
      req_event_date <= dt;
      req_price <= px;
      do @(posedge clock); while (!req_ready);
      want = next_bar(kind, tm, dt, px);
      if (typed) begin
         want = typed_bar;
      end
      pending_bars.push_back(want);
      items_sent++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pending_bars.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CsrDataW-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_BAR_CYCLE:     cfg_cycle = val[CycW-1:0];
         CSR_CHART_MODE:    cfg_mode = val[ModeW-1:0];
         CSR_SESSION_OPEN:  cfg_open = val[TimeW-1:0];
         CSR_SESSION_CLOSE: cfg_close = val[TimeW-1:0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic [CycW-1:0] cyc, input logic [ModeW-1:0] mode,
                            input logic [TimeW-1:0] so, input logic [TimeW-1:0] sc);
      settle();
      write_csr(CSR_BAR_CYCLE, CsrDataW'(cyc));
      write_csr(CSR_CHART_MODE, CsrDataW'(mode));
      write_csr(CSR_SESSION_OPEN, CsrDataW'(so));
      write_csr(CSR_SESSION_CLOSE, CsrDataW'(sc));
      csr_valid <= 1'b0;
      phases++;
   endtask

   function automatic void row(input logic kind, input logic [TimeW-1:0] tm,
                               input logic [DateW-1:0] dt, input logic signed [PriceW-1:0] px);
      script_row_type r;
      r.is_cfg = 1'b0;
      r.cyc = '0;
      r.mode = '0;
      r.sess_open = '0;
      r.sess_close = '0;
      r.kind = kind;
      r.tm = tm;
      r.dt = dt;
      r.px = px;
      r.typed = 1'b0;
      r.want = '0;
      script.push_back(r);
   endfunction

   function automatic void row_with(input logic kind, input logic [TimeW-1:0] tm,
                                    input logic [DateW-1:0] dt,
                                    input logic signed [PriceW-1:0] px, input action_type act,
                                    input logic [DateW-1:0] bd, input logic [TimeW-1:0] bt,
                                    input logic signed [PriceW-1:0] o,
                                    input logic signed [PriceW-1:0] h,
                                    input logic signed [PriceW-1:0] l,
                                    input logic signed [PriceW-1:0] c);
      row(kind, tm, dt, px);
      script[$].typed = 1'b1;
      script[$].want = '{act: act, date: bd, tm: bt, open: o, high: h, low: l, close: c};
   endfunction

   function automatic void row_cfg(input logic [CycW-1:0] cyc, input logic [ModeW-1:0] mode,
                                   input logic [TimeW-1:0] so, input logic [TimeW-1:0] sc);
      row(REQ_TRADE, '0, '0, '0);
      script[$].is_cfg = 1'b1;
      script[$].cyc = cyc;
      script[$].mode = mode;
      script[$].sess_open = so;
      script[$].sess_close = sc;
   endfunction

   initial begin
      logic                     kind;
      logic [TimeW-1:0]         tm;
      logic [DateW-1:0]         day;
      logic signed [PriceW-1:0] px;
      logic [CycW-1:0]          cyc;
      logic [ModeW-1:0]         mode;
      logic [TimeW-1:0]         so;
      logic [TimeW-1:0]         sc;
      int unsigned              secs;
      int unsigned              pick;
      int                       price_lvl;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Timer with no bar held, then update-only mode against the reset zeros.
      row_with(REQ_TIMER, 18'd120000, 27'd20240101, 32'sd5, ACT_IGNORED, '0, '0,
               32'sd0, 32'sd0, 32'sd0, 32'sd0);
      row_cfg(CycleReset, MODE_UPDATE, SessionOpenReset, SessionCloseReset);
      row_with(REQ_TRADE, 18'd100000, 27'd20240101, -32'sd5, ACT_UPDATED, '0, '0,
               32'sd0, 32'sd0, -32'sd5, -32'sd5);
      row_cfg(CycleReset, MODE_MINUTE, SessionOpenReset, SessionCloseReset);
      row_with(REQ_TRADE, 18'd093015, 27'd20240102, 32'sd100, ACT_NEW_TICK, 27'd20240102,
               18'd093000, 32'sd100, 32'sd100, 32'sd100, 32'sd100);
      row_with(REQ_TRADE, 18'd093059, 27'd20240102, 32'sh7FFFFFFF, ACT_UPDATED, 27'd20240102,
               18'd093000, 32'sd100, 32'sh7FFFFFFF, 32'sd100, 32'sh7FFFFFFF);
      row_with(REQ_TRADE, 18'd093020, 27'd20240102, 32'sh80000000, ACT_UPDATED, 27'd20240102,
               18'd093000, 32'sd100, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000);
      row(REQ_TRADE, 18'd092900, 27'd20240102, 32'sd7);
      row(REQ_TIMER, 18'd093500, 27'd20240102, 32'sd0);
      row(REQ_TIMER, 18'd093540, 27'd20240102, 32'sd0);
      row(REQ_TRADE, 18'd000030, 27'd20240103, 32'sd11);
      row(REQ_TRADE, 18'd000045, 27'd20240103, 32'sd12);
      row(REQ_TIMER, 18'd000100, 27'd20240103, 32'sd0);
      row(REQ_TRADE, 18'h3FFFF, 27'd99991231, -32'sd1);
      row(REQ_TRADE, '0, '0, 32'sd0);
      row(REQ_TRADE, 18'd235959, 27'h7FFFFFF, 32'sh55555555);
      row(REQ_TRADE, 18'd235959, 27'h7FFFFFF, 32'shAAAAAAAA);
      row(REQ_TRADE, 18'd080000, 27'd20240104, 32'sd500);
      row_cfg(6'd0, MODE_SPARE, 18'd093000, 18'd160000);
      row(REQ_TRADE, 18'd081000, 27'd20240104, 32'sd520);
      row(REQ_TIMER, 18'd070000, 27'd20240104, 32'sd0);
      row(REQ_TIMER, 18'd170000, 27'd20240104, 32'sd0);
      row(REQ_TIMER, 18'd120000, 27'd20240104, 32'sd0);
      row_cfg(6'd60, MODE_TICK, '0, 18'h3FFFF);
      row(REQ_TRADE, 18'd123000, 27'd20240104, 32'sd1);
      row(REQ_TIMER, 18'd150000, 27'd20240104, 32'sd0);
      // A session open of 10:37:45 floors to 10:30:45 with a 15 minute bar.
      row_cfg(6'd15, MODE_MINUTE, 18'd103745, 18'd113759);
      row(REQ_TRADE, 18'd101500, 27'd20240105, 32'sd40);
      row(REQ_TIMER, 18'd103050, 27'd20240105, 32'sd0);
      row(REQ_TIMER, 18'd113100, 27'd20240105, 32'sd0);

      foreach (script[i]) begin
         if (script[i].is_cfg) begin
            configure(script[i].cyc, script[i].mode, script[i].sess_open,
                      script[i].sess_close);
         end else begin
            offer_tick(script[i].kind, script[i].tm, script[i].dt, script[i].px,
                       script[i].typed, script[i].want);
         end
      end

      day = DateW'(20000101 + $urandom_range(0, 99999));
      price_lvl = int'($urandom_range(1000, 100000));
      for (int ph = 0; ph < 10; ph++) begin
         case ($urandom_range(0, 5))
            0: cyc = 6'd0;
            1: cyc = 6'd1;
            2: cyc = 6'd60;
            3: cyc = 6'd63;
            default: cyc = CycW'($urandom_range(1, 60));
         endcase
         mode = ($urandom_range(0, 99) < 60) ? MODE_MINUTE : ModeW'($urandom_range(0, 3));
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            so = SessionOpenReset;
            sc = SessionCloseReset;
         end else if (pick < 80) begin
            so = TimeW'($urandom_range(0, 120000));
            sc = TimeW'($urandom_range(120000, 235959));
         end else begin
            so = TimeW'($urandom);
            sc = TimeW'($urandom);
         end
         configure(cyc, mode, so, sc);
         quiet_req = (ph == 2 || ph == 3);
         quiet_rsp <= (ph == 2);
         if (ph == 3) begin
            fork
               hold_results(HoldCycles);
            join_none
         end
         day = day + 1'b1;
         secs = $urandom_range(0, 30000);
         for (int n = 0; n < 50; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
               kind = 1'($urandom_range(0, 1));
               tm = TimeW'($urandom_range(0, 262143));
               px = $urandom;
               if ($urandom_range(0, 1) == 0) begin
                  tm = TimeW'($urandom);
               end
               if ($urandom_range(0, 1) == 0) begin
                  day = DateW'($urandom);
               end
            end else begin
               if (pick < 11 && secs > 600) begin
                  secs = secs - $urandom_range(1, 600);
               end else begin
                  secs = secs + $urandom_range(0, 150);
               end
               if (secs >= 86400) begin
                  secs = secs - 86400;
                  day = day + 1'b1;
               end
               tm = TimeW'((secs / 3600) * 10000 + ((secs / 60) % 60) * 100 + secs % 60);
               kind = ($urandom_range(0, 4) == 0) ? REQ_TIMER : REQ_TRADE;
               price_lvl = price_lvl + int'($urandom_range(0, 40)) - 20;
               px = price_lvl;
               case ($urandom_range(0, 49))
                  0: px = 32'sh7FFFFFFF;
                  1: px = 32'sh80000000;
                  2: px = $urandom;
                  default: ;
               endcase
            end
            offer_tick(kind, tm, day, px, 1'b0, '0);
         end
      end

      settle();
      repeat (DrainCycles) @(posedge clock);
      $display("covered %0d request beats over %0d register settings, %0d bars compared",
               items_sent, phases, bars_seen);
      $display("new from trade %0d, timer fills %0d, updates %0d, ignored %0d",
               act_count[int'(ACT_NEW_TICK)], act_count[int'(ACT_NEW_TIMER)],
               act_count[int'(ACT_UPDATED)], act_count[int'(ACT_IGNORED)]);
      if (errors == 0) begin
         $display("tb_price_bar_aggregator: clean");
      end else begin
         $display("tb_price_bar_aggregator: errors");
      end
      $finish;
   end

endmodule
